### rtl/srsf_pkg.sv
// ----------------------------------------------------------------------------
// srsf_pkg
// Shared types, opcodes and name tables of the reflection strip filter.
// ----------------------------------------------------------------------------
package srsf_pkg;

	localparam int HEADER_WORDS = 5;

	localparam logic [15:0] OP_EXTENSION              = 16'd10;
	localparam logic [15:0] OP_DECORATE_ID            = 16'd332;
	localparam logic [15:0] OP_DECORATE_STRING        = 16'd5632;
	localparam logic [15:0] OP_MEMBER_DECORATE_STRING = 16'd5633;

	localparam logic [31:0] DECO_REFL_A = 32'd5634;
	localparam logic [31:0] DECO_REFL_B = 32'd5635;
	localparam logic [31:0] DECO_REFL_C = 32'd5636;

	localparam int EXT_LEN_A = 30;
	localparam int EXT_LEN_B = 20;
	localparam logic [8*EXT_LEN_A-1:0] EXT_NAME_A = {"SPV_GOOG", "LE_hlsl_functionality1"};
	localparam logic [8*EXT_LEN_B-1:0] EXT_NAME_B = {"SPV_GOOG", "LE_user_type"};

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CLASS_OTHER     = 2'd0,
		CLASS_EXTENSION = 2'd1,
		CLASS_DECORATE  = 2'd2,
		CLASS_MEMBER    = 2'd3
	} class_t;

	typedef enum logic [3:0] {
		MODE_HEADER = 4'b0001,
		MODE_HOLD   = 4'b0010,
		MODE_PASS   = 4'b0100,
		MODE_DROP   = 4'b1000
	} mode_t;

	typedef enum logic [1:0] {
		DEC_NONE = 2'd0,
		DEC_KEEP = 2'd1,
		DEC_DROP = 2'd2
	} dec_t;

	typedef struct packed {
		logic  emit_word;
		logic  flush;
		logic  status_valid;
		kind_t status_kind;
	} plan_t;

	function automatic logic [7:0] name_a_byte(input logic [4:0] i);
		logic [7:0] b;
		b = 8'h00;
		if (i < 5'(EXT_LEN_A)) begin
			b = EXT_NAME_A[8*(EXT_LEN_A-1-int'(i)) +: 8];
		end
		return b;
	endfunction

	function automatic logic [7:0] name_b_byte(input logic [4:0] i);
		logic [7:0] b;
		b = 8'h00;
		if (i < 5'(EXT_LEN_B)) begin
			b = EXT_NAME_B[8*(EXT_LEN_B-1-int'(i)) +: 8];
		end
		return b;
	endfunction

	function automatic logic is_refl_deco(input logic [31:0] d);
		return (d == DECO_REFL_A) || (d == DECO_REFL_B) || (d == DECO_REFL_C);
	endfunction

endpackage

### rtl/srsf_in_if.sv
// ----------------------------------------------------------------------------
// srsf_in_if
// Word stream channel into the filter: valid/ready with word and last mark.
// ----------------------------------------------------------------------------
interface srsf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] in_word;
	logic        in_last;

	modport source (output valid, output in_word, output in_last, input ready);
	modport sink (input valid, input in_word, input in_last, output ready);
endinterface

### rtl/srsf_out_if.sv
// ----------------------------------------------------------------------------
// srsf_out_if
// Result channel out of the filter: valid/ready with word, kind and run mark.
// ----------------------------------------------------------------------------
interface srsf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word;
	logic [1:0]  out_kind;
	logic        run_last;

	modport source (output valid, output out_word, output out_kind, output run_last,
		input ready);
	modport sink (input valid, input out_word, input out_kind, input run_last,
		output ready);
endinterface

### rtl/srsf_name_match.sv
// ----------------------------------------------------------------------------
// srsf_name_match
// Compares the four bytes of one extension name word against both names.
// ----------------------------------------------------------------------------
module srsf_name_match (
	input  logic [31:0]    word,
	input  logic [1:0]     flags_in,
	input  logic [4:0]     idx_in,
	output srsf_pkg::dec_t dec,
	output logic [1:0]     flags_out,
	output logic [4:0]     idx_out
);
	import srsf_pkg::*;

	logic [7:0] b;
	logic [1:0] f;
	logic [4:0] i;
	logic       done;

	always_comb begin
		dec  = DEC_NONE;
		f    = flags_in;
		i    = idx_in;
		done = 1'b0;
		b    = 8'h00;
		for (int k = 0; k < 4; k++) begin
			if (!done) begin
				b = word[8*k +: 8];
				if (b == 8'h00) begin
					dec  = ((f[0] && i == 5'(EXT_LEN_A)) || (f[1] && i == 5'(EXT_LEN_B)))
						? DEC_DROP : DEC_KEEP;
					done = 1'b1;
				end else begin
					if (name_a_byte(i) != b) begin
						f[0] = 1'b0;
					end
					if (name_b_byte(i) != b) begin
						f[1] = 1'b0;
					end
					if (f == 2'b00) begin
						dec  = DEC_KEEP;
						done = 1'b1;
					end else if (i < 5'd31) begin
						i = i + 5'd1;
					end
				end
			end
		end
		flags_out = f;
		idx_out   = i;
	end

endmodule

### rtl/srsf_head_buf.sv
// ----------------------------------------------------------------------------
// srsf_head_buf
// Holds the head words of an instruction that is still undecided.
// ----------------------------------------------------------------------------
module srsf_head_buf #(
	parameter  int HEAD_DEPTH = 9,
	localparam int IDX_W      = $clog2(HEAD_DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [31:0]      wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [31:0]      rdata
);
	logic [31:0] words_q [HEAD_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			words_q[waddr] <= wdata;
		end
	end

	assign rdata = words_q[raddr];

endmodule

### rtl/srsf_framer.sv
// ----------------------------------------------------------------------------
// srsf_framer
// Header count, instruction framing and the keep/drop decision per word.
// ----------------------------------------------------------------------------
module srsf_framer #(
	parameter  int HEAD_DEPTH = 9,
	localparam int IDX_W      = $clog2(HEAD_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [31:0]      word,
	input  logic             last,
	output srsf_pkg::plan_t  plan,
	output logic [IDX_W-1:0] flush_end,
	output logic             hb_we,
	output logic [IDX_W-1:0] hb_addr
);
	import srsf_pkg::*;

	logic [2:0]  hdr_q, hdr_n;
	logic [15:0] pos_q, pos_n, len_q, len_n;
	class_t      class_q, class_n;
	mode_t       mode_q, mode_n;
	logic [1:0]  flags_q, flags_n;
	logic [4:0]  idx_q, idx_n;
	logic        malformed_q, malformed_n;

	logic        framing, start;
	logic [15:0] pos_eff, len_eff;
	class_t      class_eff;
	mode_t       mode_eff;
	logic [1:0]  flags_eff;
	logic [4:0]  idx_eff;
	logic [16:0] pos_inc;
	dec_t        dec, nm_dec;
	logic [1:0]  nm_flags;
	logic [4:0]  nm_idx;

	assign framing = !malformed_q && (hdr_q >= 3'(HEADER_WORDS));
	assign start   = framing && (pos_q >= len_q) && (word[31:16] != 16'd0);

	always_comb begin
		pos_eff   = pos_q;
		len_eff   = len_q;
		class_eff = class_q;
		mode_eff  = mode_q;
		flags_eff = flags_q;
		idx_eff   = idx_q;
		if (start) begin
			pos_eff   = 16'd0;
			len_eff   = word[31:16];
			flags_eff = 2'b11;
			idx_eff   = 5'd0;
			priority if (word[15:0] == OP_EXTENSION) begin
				class_eff = CLASS_EXTENSION;
			end else if (word[15:0] == OP_DECORATE_ID || word[15:0] == OP_DECORATE_STRING) begin
				class_eff = CLASS_DECORATE;
			end else if (word[15:0] == OP_MEMBER_DECORATE_STRING) begin
				class_eff = CLASS_MEMBER;
			end else begin
				class_eff = CLASS_OTHER;
			end
			mode_eff = (class_eff == CLASS_OTHER) ? MODE_PASS : MODE_HOLD;
		end
	end

	srsf_name_match u_name_match (
		.word      (word),
		.flags_in  (flags_eff),
		.idx_in    (idx_eff),
		.dec       (nm_dec),
		.flags_out (nm_flags),
		.idx_out   (nm_idx)
	);

	assign pos_inc   = {1'b0, pos_eff} + 17'd1;
	assign flush_end = pos_eff[IDX_W-1:0];
	assign hb_addr   = pos_eff[IDX_W-1:0];

	always_comb begin
		hdr_n       = hdr_q;
		pos_n       = pos_q;
		len_n       = len_eff;
		class_n     = class_eff;
		mode_n      = mode_eff;
		flags_n     = flags_eff;
		idx_n       = idx_eff;
		malformed_n = malformed_q;
		plan        = '0;
		plan.status_kind = KIND_OK;
		hb_we       = 1'b0;
		dec         = DEC_NONE;
		if (malformed_q) begin
			// nothing more for this module
		end else if (hdr_q < 3'(HEADER_WORDS)) begin
			plan.emit_word = 1'b1;
			hdr_n = hdr_q + 3'd1;
			if (hdr_n >= 3'(HEADER_WORDS)) begin
				mode_n = MODE_PASS;
			end
		end else if ((pos_q >= len_q) && !start) begin
			malformed_n = 1'b1;
		end else begin
			pos_n = pos_inc[15:0];
			unique case (mode_eff)
				MODE_PASS: begin
					plan.emit_word = 1'b1;
				end
				MODE_HOLD: begin
					hb_we = (pos_eff < 16'(HEAD_DEPTH));
					if (class_eff == CLASS_DECORATE && pos_eff == 16'd2) begin
						dec = is_refl_deco(word) ? DEC_DROP : DEC_KEEP;
					end else if (class_eff == CLASS_MEMBER && pos_eff == 16'd3) begin
						dec = is_refl_deco(word) ? DEC_DROP : DEC_KEEP;
					end else if (class_eff == CLASS_EXTENSION && pos_eff >= 16'd1) begin
						dec     = nm_dec;
						flags_n = nm_flags;
						idx_n   = nm_idx;
					end
					if (dec == DEC_NONE &&
						(pos_inc >= {1'b0, len_eff} || pos_inc >= 17'(HEAD_DEPTH))) begin
						dec = DEC_KEEP;
					end
					if (dec == DEC_KEEP) begin
						plan.flush = 1'b1;
						mode_n     = MODE_PASS;
					end else if (dec == DEC_DROP) begin
						mode_n = MODE_DROP;
					end
				end
				default: begin
				end
			endcase
		end
		if (last) begin
			plan.status_valid = 1'b1;
			plan.status_kind  = (malformed_n || hdr_n < 3'(HEADER_WORDS) || pos_n < len_n)
				? KIND_BAD : KIND_OK;
			hdr_n       = 3'd0;
			pos_n       = 16'd0;
			len_n       = 16'd0;
			class_n     = CLASS_OTHER;
			mode_n      = MODE_HEADER;
			flags_n     = 2'b11;
			idx_n       = 5'd0;
			malformed_n = 1'b0;
		end
		hb_we = hb_we && take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q       <= 3'd0;
			pos_q       <= 16'd0;
			len_q       <= 16'd0;
			class_q     <= CLASS_OTHER;
			mode_q      <= MODE_HEADER;
			flags_q     <= 2'b11;
			idx_q       <= 5'd0;
			malformed_q <= 1'b0;
		end else if (take) begin
			hdr_q       <= hdr_n;
			pos_q       <= pos_n;
			len_q       <= len_n;
			class_q     <= class_n;
			mode_q      <= mode_n;
			flags_q     <= flags_n;
			idx_q       <= idx_n;
			malformed_q <= malformed_n;
		end
	end

endmodule

### rtl/spirv_reflection_strip_filter.sv
// ----------------------------------------------------------------------------
// spirv_reflection_strip_filter
// Strips reflection extensions and decorations from a SPIR-V word stream.
// ----------------------------------------------------------------------------
// stream carries one module word per transfer, in_last on its final word.
// result carries kept words (kind data) and, after the final word, one
// status result (kind ok or malformed); run_last marks the last result
// caused by each input word. A malformed module's words are to be discarded.
// a word passes an input register and then the result register, which shows
// its first result. Header words and words of instructions already decided
// are taken at one word per cycle while result is not stalled. A word that
// decides to keep a held instruction releases up to HEAD_DEPTH held words,
// one per cycle from the head buffer while result is not stalled, and
// intake pauses for that flush; a pending status result pauses it too.
// reset clears framing state, the input valid and the result register; held words need no clear.
// when result is stalled the result register holds its value and the input
// register takes one more word only if it is empty, then stream.ready drops.
// ----------------------------------------------------------------------------
module spirv_reflection_strip_filter #(
	parameter int HEAD_DEPTH = 9
) (
	input logic        clk,
	input logic        arst_n,
	srsf_in_if.sink    stream,
	srsf_out_if.source result
);
	import srsf_pkg::*;

	localparam int IDX_W = $clog2(HEAD_DEPTH);

	logic             valid_s1;
	logic [31:0]      word_s1;
	logic             last_s1;

	logic             out_valid_q;
	logic [31:0]      out_word_q;
	kind_t            out_kind_q;
	logic             out_run_last_q;

	logic             flush_active_q;
	logic [IDX_W-1:0] flush_idx_q;
	logic [IDX_W-1:0] flush_end_q;
	logic             status_pend_q;
	kind_t            status_kind_q;

	logic             out_free, take;
	plan_t            plan;
	logic [IDX_W-1:0] flush_end;
	logic             hb_we;
	logic [IDX_W-1:0] hb_addr, hb_raddr;
	logic [31:0]      hb_rdata;

	assign out_free     = !out_valid_q || result.ready;
	assign take         = valid_s1 && !flush_active_q && !status_pend_q && out_free;
	assign stream.ready = !valid_s1 || take;
	assign hb_raddr     = flush_active_q ? flush_idx_q : '0;

	srsf_framer #(.HEAD_DEPTH(HEAD_DEPTH)) u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.word      (word_s1),
		.last      (last_s1),
		.plan      (plan),
		.flush_end (flush_end),
		.hb_we     (hb_we),
		.hb_addr   (hb_addr)
	);

	srsf_head_buf #(.HEAD_DEPTH(HEAD_DEPTH)) u_head_buf (
		.clk   (clk),
		.we    (hb_we),
		.waddr (hb_addr),
		.wdata (word_s1),
		.raddr (hb_raddr),
		.rdata (hb_rdata)
	);

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			word_s1 <= stream.in_word;
			last_s1 <= stream.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			out_word_q     <= 32'd0;
			out_kind_q     <= KIND_DATA;
			out_run_last_q <= 1'b0;
			flush_active_q <= 1'b0;
			flush_idx_q    <= '0;
			flush_end_q    <= '0;
			status_pend_q  <= 1'b0;
			status_kind_q  <= KIND_OK;
		end else begin
			if (stream.valid && stream.ready) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				if (flush_active_q) begin
					out_valid_q    <= 1'b1;
					out_word_q     <= hb_rdata;
					out_kind_q     <= KIND_DATA;
					out_run_last_q <= (flush_idx_q == flush_end_q) && !status_pend_q;
					flush_idx_q    <= flush_idx_q + IDX_W'(1);
					if (flush_idx_q == flush_end_q) begin
						flush_active_q <= 1'b0;
					end
				end else if (status_pend_q) begin
					out_valid_q    <= 1'b1;
					out_word_q     <= 32'd0;
					out_kind_q     <= status_kind_q;
					out_run_last_q <= 1'b1;
					status_pend_q  <= 1'b0;
				end else if (take) begin
					status_pend_q <= plan.status_valid && (plan.emit_word || plan.flush);
					status_kind_q <= plan.status_kind;
					priority if (plan.emit_word) begin
						out_valid_q    <= 1'b1;
						out_word_q     <= word_s1;
						out_kind_q     <= KIND_DATA;
						out_run_last_q <= !plan.status_valid;
					end else if (plan.flush) begin
						out_valid_q    <= 1'b1;
						out_word_q     <= (flush_end == '0) ? word_s1 : hb_rdata;
						out_kind_q     <= KIND_DATA;
						out_run_last_q <= (flush_end == '0) && !plan.status_valid;
						flush_end_q    <= flush_end;
						if (flush_end != '0) begin
							flush_active_q <= 1'b1;
							flush_idx_q    <= IDX_W'(1);
						end
					end else if (plan.status_valid) begin
						out_valid_q    <= 1'b1;
						out_word_q     <= 32'd0;
						out_kind_q     <= plan.status_kind;
						out_run_last_q <= 1'b1;
					end else begin
						out_valid_q <= 1'b0;
					end
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_word = out_word_q;
	assign result.out_kind = out_kind_q;
	assign result.run_last = out_run_last_q;

endmodule

### rtl/srsf_checker.sv
// ----------------------------------------------------------------------------
// srsf_checker
// Port-level checks of the result channel, bound to the filter top level.
// ----------------------------------------------------------------------------
module srsf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_word,
	input logic [1:0]  out_kind,
	input logic        out_run_last
);
	import srsf_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_kind)
			&& $stable(out_run_last))
		else $error("stalled result changed");

	// status results carry a zero word and close the run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_DATA |-> out_word == 32'd0 && out_run_last)
		else $error("status result with data or open run");

	// nothing is shown on the first edge after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind spirv_reflection_strip_filter srsf_checker u_srsf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_word     (result.out_word),
	.out_kind     (result.out_kind),
	.out_run_last (result.run_last)
);
